/* hw/rtl/srlr_pkg.sv */
`default_nettype none

package srlr_pkg;

	typedef logic signed [23:0] sample_t;
	typedef logic [22:0] step_t;
	typedef logic [20:0] weight_t;

	typedef struct packed {
		logic    mode;
		sample_t left_sample;
		sample_t right_sample;
	} item_t;

	typedef struct packed {
		sample_t out_left;
		sample_t out_right;
		logic    sample_valid;
	} result_t;

	typedef enum logic [1:0] {
		CTRL_IDLE,
		CTRL_INTERP,
		CTRL_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic    valid;
		weight_t weight;
	} issue_t;

	typedef struct packed {
		logic busy;
	} ctrl_stat_t;

	typedef struct packed {
		logic nonempty;
	} fifo_stat_t;

	typedef struct packed {
		logic    valid;
		sample_t left_sample;
		sample_t right_sample;
	} fifo_wr_t;

	localparam logic  MODE_PUSH      = 1'b0;
	localparam logic  MODE_POP       = 1'b1;
	localparam logic  REG_STEP_RATIO = 1'b0;
	localparam step_t ONE_Q20        = 23'd1048576;
	localparam step_t STEP_MIN       = 23'd262144;
	localparam step_t STEP_MAX       = 23'd4194304;
	localparam step_t STEP_RESET     = 23'd1048576;

endpackage

`default_nettype wire

/* hw/rtl/srlr_lane.sv */
`default_nettype none

module srlr_lane (
	input  wire logic              clk,
	input  wire srlr_pkg::sample_t prev_sample,
	input  wire srlr_pkg::sample_t cur_sample,
	input  wire srlr_pkg::weight_t weight,
	output srlr_pkg::sample_t      lerp
);
	import srlr_pkg::*;

	logic signed [24:0] diff;
	logic signed [46:0] prod_s1;
	logic signed [46:0] rounded;
	logic signed [46:0] quot;
	sample_t            prev_s1;
	sample_t            lerp_s2;

	assign diff    = 25'(cur_sample) - 25'(prev_sample);
	assign rounded = prod_s1 + 47'sd524288;
	assign quot    = rounded >>> 20;

	always_ff @(posedge clk) begin
		prod_s1 <= 47'(diff) * 47'(signed'({1'b0, weight}));
		prev_s1 <= prev_sample;
		lerp_s2 <= prev_s1 + quot[23:0];
	end

	assign lerp = lerp_s2;

endmodule

`default_nettype wire

/* hw/rtl/srlr_fifo.sv */
`default_nettype none

module srlr_fifo #(
	parameter int DEPTH = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srlr_pkg::fifo_wr_t wr,
	input  wire logic               rd_en,
	output srlr_pkg::sample_t       rd_left,
	output srlr_pkg::sample_t       rd_right,
	output logic                    rd_hit,
	output srlr_pkg::fifo_stat_t    stat
);
	import srlr_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sample_t          mem_left  [DEPTH];
	sample_t          mem_right [DEPTH];
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] count_q;
	sample_t          rd_left_q;
	sample_t          rd_right_q;
	logic             rd_hit_q;
	logic             wr_ok;
	logic             rd_ok;

	assign wr_ok = wr.valid && (count_q < CNT_W'(DEPTH - 1));
	assign rd_ok = rd_en && (count_q != '0);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_left[wr_idx_q]  <= wr.left_sample;
			mem_right[wr_idx_q] <= wr.right_sample;
		end
		if (rd_en) begin
			rd_left_q  <= mem_left[rd_idx_q];
			rd_right_q <= mem_right[rd_idx_q];
			rd_hit_q   <= (count_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_idx_q <= (wr_idx_q == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (rd_ok) begin
				rd_idx_q <= (rd_idx_q == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			unique case ({wr_ok, rd_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_left       = rd_left_q;
	assign rd_right      = rd_right_q;
	assign rd_hit        = rd_hit_q;
	assign stat.nonempty = (count_q != '0);

endmodule

`default_nettype wire

/* hw/rtl/srlr_ctrl.sv */
`default_nettype none

module srlr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire srlr_pkg::item_t   item,
	input  wire srlr_pkg::step_t   step_ratio,
	input  wire logic              drained,
	output srlr_pkg::issue_t       issue,
	output srlr_pkg::ctrl_stat_t   stat,
	output srlr_pkg::sample_t      prev_left,
	output srlr_pkg::sample_t      prev_right,
	output srlr_pkg::sample_t      cur_left,
	output srlr_pkg::sample_t      cur_right
);
	import srlr_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	step_t       t_q;
	step_t       phase_q;
	step_t       step_eff;
	logic [23:0] t_sum;
	logic        t_in_range;
	logic        have_prev_q;
	sample_t     prev_left_q;
	sample_t     prev_right_q;
	sample_t     cur_left_q;
	sample_t     cur_right_q;

	always_comb begin
		priority if (step_ratio < STEP_MIN) begin
			step_eff = STEP_MIN;
		end else if (step_ratio > STEP_MAX) begin
			step_eff = STEP_MAX;
		end else begin
			step_eff = step_ratio;
		end
	end

	assign t_in_range = (t_q <= ONE_Q20);
	assign t_sum      = {1'b0, t_q} + {1'b0, step_eff};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTRL_IDLE:   if (push) state_d = CTRL_INTERP;
			CTRL_INTERP: if (!t_in_range) state_d = CTRL_DRAIN;
			CTRL_DRAIN:  if (drained) state_d = CTRL_IDLE;
			default:     state_d = CTRL_IDLE;
		endcase
	end

	always_comb begin
		issue.valid  = (state_q == CTRL_INTERP) && t_in_range;
		issue.weight = t_q[20:0];
		stat.busy    = (state_q != CTRL_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CTRL_IDLE;
			phase_q      <= '0;
			have_prev_q  <= 1'b0;
			prev_left_q  <= '0;
			prev_right_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == CTRL_INTERP) && !t_in_range) begin
				phase_q      <= t_q - ONE_Q20;
				have_prev_q  <= 1'b1;
				prev_left_q  <= cur_left_q;
				prev_right_q <= cur_right_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cur_left_q  <= item.left_sample;
			cur_right_q <= item.right_sample;
			t_q         <= have_prev_q ? phase_q : ONE_Q20;
		end else if (issue.valid) begin
			t_q <= t_sum[22:0];
		end
	end

	assign prev_left  = prev_left_q;
	assign prev_right = prev_right_q;
	assign cur_left   = cur_left_q;
	assign cur_right  = cur_right_q;

endmodule

`default_nettype wire

/* hw/rtl/stereo_linear_resampler_fifo.sv */
`default_nettype none

// A push beat (mode 0) carries one source stereo frame and produces no result; it stalls the
// input until its N interpolated samples (N from 0 to 4) have passed the one-sample-per-cycle
// interpolation sequencer, the two-stage multiply pipeline of the channel lanes and the single
// FIFO write port. A pop beat (mode 1) returns the oldest sample in the next cycle from the
// registered FIFO read port, or silence with sample_valid low when the FIFO is empty; a push
// may be accepted while that result waits. Samples are dropped when the FIFO holds
// FIFO_DEPTH - 1 entries, and the FIFO memory needs no clearing pass after reset.
module stereo_linear_resampler_fifo #(
	parameter int FIFO_DEPTH = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire srlr_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output srlr_pkg::result_t      result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import srlr_pkg::*;

	step_t      step_q;
	logic       push_acc;
	logic       pop_acc;
	logic       v_s1;
	logic       v_s2;
	logic       drained;
	logic       result_valid_q;
	issue_t     issue;
	ctrl_stat_t cstat;
	fifo_stat_t fstat;
	fifo_wr_t   wr;
	sample_t    prev_left;
	sample_t    prev_right;
	sample_t    cur_left;
	sample_t    cur_right;
	sample_t    lerp_left;
	sample_t    lerp_right;
	sample_t    rd_left;
	sample_t    rd_right;
	logic       rd_hit;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_STEP_RATIO) ? {9'd0, step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == REG_STEP_RATIO)) begin
			step_q <= pwdata[22:0];
		end
	end

	assign item_stall = cstat.busy ||
		((item.mode == MODE_POP) && result_valid_q && result_stall);
	assign push_acc   = item_valid && !item_stall && (item.mode == MODE_PUSH);
	assign pop_acc    = item_valid && !item_stall && (item.mode == MODE_POP);
	assign drained    = !v_s1 && !v_s2;

	srlr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_acc),
		.item       (item),
		.step_ratio (step_q),
		.drained    (drained),
		.issue      (issue),
		.stat       (cstat),
		.prev_left  (prev_left),
		.prev_right (prev_right),
		.cur_left   (cur_left),
		.cur_right  (cur_right)
	);

	srlr_lane u_lane_left (
		.clk         (clk),
		.prev_sample (prev_left),
		.cur_sample  (cur_left),
		.weight      (issue.weight),
		.lerp        (lerp_left)
	);

	srlr_lane u_lane_right (
		.clk         (clk),
		.prev_sample (prev_right),
		.cur_sample  (cur_right),
		.weight      (issue.weight),
		.lerp        (lerp_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
		end
	end

	assign wr.valid        = v_s2;
	assign wr.left_sample  = lerp_left;
	assign wr.right_sample = lerp_right;

	srlr_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_en    (pop_acc),
		.rd_left  (rd_left),
		.rd_right (rd_right),
		.rd_hit   (rd_hit),
		.stat     (fstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop_acc) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid        = result_valid_q;
	assign result.out_left     = rd_hit ? rd_left : '0;
	assign result.out_right    = rd_hit ? rd_right : '0;
	assign result.sample_valid = rd_hit;

	a_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push_acc |=> cstat.busy)
		else $error("push beat did not start the interpolation sequence");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!cstat.busy |-> drained)
		else $error("interpolation pipeline still busy while the sequencer is idle");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_acc && !fstat.nonempty) |=> (result_valid && !result.sample_valid))
		else $error("pop from an empty FIFO did not return silence");

endmodule

`default_nettype wire
